[rtl/rtc_pkg.sv]
package rtc_pkg;

	// Field widths
	localparam int unsigned HOUR_W    = 5;
	localparam int unsigned MIN_W     = 6;
	localparam int unsigned SEC_W     = 6;
	localparam int unsigned WDAY_W    = 3;
	localparam int unsigned DAY_W     = 5;
	localparam int unsigned MONTH_W   = 4;
	localparam int unsigned YEAR_W    = 14;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 7;

	// Counter limits
	localparam logic [SEC_W-1:0]   SEC_LAST   = SEC_W'(59);
	localparam logic [MIN_W-1:0]   MIN_LAST   = MIN_W'(59);
	localparam logic [HOUR_W-1:0]  HOUR_LAST  = HOUR_W'(23);
	localparam logic [WDAY_W-1:0]  WDAY_LAST  = WDAY_W'(6);
	localparam logic [WDAY_W-1:0]  WDAY_NONE  = WDAY_W'(7);
	localparam logic [YEAR_W-1:0]  YEAR_LAST  = YEAR_W'(9999);

	// Month numbers with special lengths, and the first and last month
	localparam logic [MONTH_W-1:0] MON_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MON_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MON_APR = MONTH_W'(4);
	localparam logic [MONTH_W-1:0] MON_JUN = MONTH_W'(6);
	localparam logic [MONTH_W-1:0] MON_SEP = MONTH_W'(9);
	localparam logic [MONTH_W-1:0] MON_NOV = MONTH_W'(11);
	localparam logic [MONTH_W-1:0] MON_DEC = MONTH_W'(12);

	localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);
	localparam logic [DAY_W-1:0]   LEN_28    = DAY_W'(28);
	localparam logic [DAY_W-1:0]   LEN_29    = DAY_W'(29);
	localparam logic [DAY_W-1:0]   LEN_30    = DAY_W'(30);
	localparam logic [DAY_W-1:0]   LEN_31    = DAY_W'(31);

	// Reset values
	localparam logic [WDAY_W-1:0]  WDAY_RST  = WDAY_W'(6);
	localparam logic [YEAR_W-1:0]  YEAR_RST  = YEAR_W'(2000);

	// y / 100 as (y * 5243) >> 19, exact for every 14-bit year
	localparam int unsigned        RECIP_W      = 13;
	localparam logic [RECIP_W-1:0] RECIP_100    = RECIP_W'(5243);
	localparam int unsigned        DIV100_SHIFT = 19;
	localparam int unsigned        PROD_W       = YEAR_W + RECIP_W;
	localparam int unsigned        CENT_W       = 8;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_LOAD = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALARM_HOUR  = 2'd0,
		CFG_ALARM_MIN   = 2'd1,
		CFG_ALARM_EN    = 2'd2,
		CFG_ALARM_DAYS  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
		logic [WDAY_W-1:0]  weekday;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic               fire;
	} rtc_word_t;

	// Gregorian leap rule
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [PROD_W-1:0] prod;
		logic [CENT_W-1:0] cent;
		logic [YEAR_W-1:0] cent_x100;
		logic              div100;
		prod      = PROD_W'(y) * PROD_W'(RECIP_100);
		cent      = prod[DIV100_SHIFT +: CENT_W];
		// cent * 100 = cent * 64 + cent * 32 + cent * 4
		cent_x100 = YEAR_W'({cent, 6'b0}) + YEAR_W'({cent, 5'b0}) + YEAR_W'({cent, 2'b0});
		div100    = (cent_x100 == y);
		return ((y[1:0] == 2'b00) && !div100) || (div100 && (cent[1:0] == 2'b00));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			MON_FEB:                            len = leap ? LEN_29 : LEN_28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
			default:                            len = LEN_31;
		endcase
		return len;
	endfunction

endpackage

[rtl/rtc_calendar_alarm.sv]
// Throughput: one word per cycle while the skid register is empty; the
// next-state and alarm logic is one registered pass from the counter
// registers to the output register.
// A skid register keeps the input open for one word while the output stalls.
// Reset: time 00:00:00, Saturday, 1 January 2000; alarm registers cleared.
module rtc_calendar_alarm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            opcode,
	input  logic [rtc_pkg::HOUR_W-1:0]      load_hour,
	input  logic [rtc_pkg::MIN_W-1:0]       load_minute,
	input  logic [rtc_pkg::SEC_W-1:0]       load_second,
	input  logic [rtc_pkg::WDAY_W-1:0]      load_weekday,
	input  logic [rtc_pkg::DAY_W-1:0]       load_day,
	input  logic [rtc_pkg::MONTH_W-1:0]     load_month,
	input  logic [rtc_pkg::YEAR_W-1:0]      load_year,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rtc_pkg::HOUR_W-1:0]      cur_hour,
	output logic [rtc_pkg::MIN_W-1:0]       cur_minute,
	output logic [rtc_pkg::SEC_W-1:0]       cur_second,
	output logic [rtc_pkg::WDAY_W-1:0]      cur_weekday,
	output logic [rtc_pkg::DAY_W-1:0]       cur_day,
	output logic [rtc_pkg::MONTH_W-1:0]     cur_month,
	output logic [rtc_pkg::YEAR_W-1:0]      cur_year,
	output logic                            alarm_fire,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rtc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rtc_pkg::CFG_DAT_W-1:0]   cfg_data
);
	import rtc_pkg::*;

	// Alarm registers
	logic [HOUR_W-1:0] alarm_hour_q;
	logic [MIN_W-1:0]  alarm_min_q;
	logic              alarm_en_q;
	logic [6:0]        alarm_days_q;

	// Time and date counters
	logic [SEC_W-1:0]   sec_q;
	logic [MIN_W-1:0]   min_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [WDAY_W-1:0]  wday_q;
	logic [DAY_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;

	// Output and skid registers
	rtc_word_t out_q;
	rtc_word_t skid_q;
	logic      out_valid_q;
	logic      skid_valid_q;

	logic      in_accept;
	logic      out_take;
	rtc_word_t nxt;
	logic      sec_wrap, min_wrap, hour_wrap, midnight;
	logic      day_wrap, month_wrap;
	logic [DAY_W-1:0] mlen;
	logic [7:0] days_ext;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign in_accept = in_valid && in_ready;
	assign out_take  = out_valid_q && out_ready;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_hour_q <= '0;
			alarm_min_q  <= '0;
			alarm_en_q   <= 1'b0;
			alarm_days_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ALARM_HOUR: alarm_hour_q <= cfg_data[HOUR_W-1:0];
				CFG_ALARM_MIN:  alarm_min_q  <= cfg_data[MIN_W-1:0];
				CFG_ALARM_EN:   alarm_en_q   <= cfg_data[0];
				CFG_ALARM_DAYS: alarm_days_q <= cfg_data[6:0];
				default:        alarm_en_q   <= alarm_en_q;
			endcase
		end
	end

	// Carry chain and next time/date
	always_comb begin
		sec_wrap   = (sec_q >= SEC_LAST);
		min_wrap   = (min_q >= MIN_LAST);
		hour_wrap  = (hour_q >= HOUR_LAST);
		midnight   = sec_wrap && min_wrap && hour_wrap;
		mlen       = month_len(month_q, is_leap(year_q));
		day_wrap   = (day_q >= mlen);
		month_wrap = (month_q >= MON_DEC);
		days_ext   = {1'b0, alarm_days_q};

		nxt = '0;
		if (opcode_t'(opcode) == OP_LOAD) begin
			nxt.hour    = load_hour;
			nxt.minute  = load_minute;
			nxt.second  = load_second;
			nxt.weekday = load_weekday;
			nxt.day     = load_day;
			nxt.month   = load_month;
			nxt.year    = load_year;
			nxt.fire    = 1'b0;
		end else begin
			nxt.second  = sec_wrap ? '0 : sec_q + SEC_W'(1);
			nxt.minute  = !sec_wrap ? min_q : (min_wrap ? '0 : min_q + MIN_W'(1));
			nxt.hour    = !(sec_wrap && min_wrap) ? hour_q
				: (hour_wrap ? '0 : hour_q + HOUR_W'(1));
			nxt.weekday = wday_q;
			nxt.day     = day_q;
			nxt.month   = month_q;
			nxt.year    = year_q;
			if (midnight) begin
				nxt.weekday = (wday_q >= WDAY_LAST) ? '0 : wday_q + WDAY_W'(1);
				if (day_wrap) begin
					nxt.day = DAY_FIRST;
					if (month_wrap) begin
						nxt.month = MON_JAN;
						nxt.year  = (year_q >= YEAR_LAST) ? '0 : year_q + YEAR_W'(1);
					end else begin
						nxt.month = month_q + MONTH_W'(1);
					end
				end else begin
					nxt.day = day_q + DAY_W'(1);
				end
			end
			// weekday 7 matches no mask bit
			nxt.fire = alarm_en_q && (nxt.weekday != WDAY_NONE) && days_ext[nxt.weekday]
				&& (nxt.hour == alarm_hour_q) && (nxt.minute == alarm_min_q)
				&& (nxt.second == '0);
		end
	end

	// Counter update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q   <= '0;
			min_q   <= '0;
			hour_q  <= '0;
			wday_q  <= WDAY_RST;
			day_q   <= DAY_FIRST;
			month_q <= MON_JAN;
			year_q  <= YEAR_RST;
		end else if (in_accept) begin
			sec_q   <= nxt.second;
			min_q   <= nxt.minute;
			hour_q  <= nxt.hour;
			wday_q  <= nxt.weekday;
			day_q   <= nxt.day;
			month_q <= nxt.month;
			year_q  <= nxt.year;
		end
	end

	// Output / skid valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= in_accept;
			end
		end else if (in_accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output / skid payload
	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_accept) begin
				out_q <= nxt;
			end
		end else if (in_accept) begin
			skid_q <= nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign cur_hour    = out_q.hour;
	assign cur_minute  = out_q.minute;
	assign cur_second  = out_q.second;
	assign cur_weekday = out_q.weekday;
	assign cur_day     = out_q.day;
	assign cur_month   = out_q.month;
	assign cur_year    = out_q.year;
	assign alarm_fire  = out_q.fire;

`ifndef SYNTHESIS
	// skid only fills behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word present without output word");

	// a load takes effect on the counters at once
	a_load_sets_year: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && opcode_t'(opcode) == OP_LOAD) |=> (year_q == $past(load_year)))
		else $error("load did not set year");

	// an alarm word always shows second zero
	a_fire_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.fire) |-> (out_q.second == '0))
		else $error("alarm fired at nonzero second");

	// a tick word never reports an alarm while disabled
	a_fire_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && nxt.fire) |-> alarm_en_q)
		else $error("alarm fired while disabled");
`endif

endmodule

[verif/rtc_checker.sv]
`timescale 1ns / 100ps

module rtc_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            opcode,
	input  logic [rtc_pkg::HOUR_W-1:0]      load_hour,
	input  logic [rtc_pkg::MIN_W-1:0]       load_minute,
	input  logic [rtc_pkg::SEC_W-1:0]       load_second,
	input  logic [rtc_pkg::WDAY_W-1:0]      load_weekday,
	input  logic [rtc_pkg::DAY_W-1:0]       load_day,
	input  logic [rtc_pkg::MONTH_W-1:0]     load_month,
	input  logic [rtc_pkg::YEAR_W-1:0]      load_year,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [rtc_pkg::HOUR_W-1:0]      cur_hour,
	input  logic [rtc_pkg::MIN_W-1:0]       cur_minute,
	input  logic [rtc_pkg::SEC_W-1:0]       cur_second,
	input  logic [rtc_pkg::WDAY_W-1:0]      cur_weekday,
	input  logic [rtc_pkg::DAY_W-1:0]       cur_day,
	input  logic [rtc_pkg::MONTH_W-1:0]     cur_month,
	input  logic [rtc_pkg::YEAR_W-1:0]      cur_year,
	input  logic                            alarm_fire,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [rtc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rtc_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                            end_of_test,
	output int                              fail_count,
	output int                              pending
);
	import rtc_pkg::*;

	localparam int SHOW_LIMIT = 10;

	// Shadow clock and calendar
	logic [HOUR_W-1:0]  hr_q;
	logic [MIN_W-1:0]   min_q;
	logic [SEC_W-1:0]   sec_q;
	logic [WDAY_W-1:0]  wday_q;
	logic [DAY_W-1:0]   day_q;
	logic [MONTH_W-1:0] mon_q;
	logic [YEAR_W-1:0]  yr_q;

	// Shadow alarm registers
	logic [HOUR_W-1:0]  al_hour;
	logic [MIN_W-1:0]   al_min;
	logic               al_en;
	logic [6:0]         al_days;

	rtc_word_t          readings_due[$];
	int                 shown;
	bit                 leftover_done;

	function automatic bit leap_year(int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	// Months 0 and 13..15 fall through to 31 days
	function automatic int unsigned month_days(int unsigned m, int unsigned y);
		if (m == 2)
			return leap_year(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	// Midnight carry into weekday, day, month and year
	function automatic void roll_date();
		wday_q = (wday_q >= 6) ? '0 : wday_q + 1'b1;
		if (day_q >= month_days(mon_q, yr_q)) begin
			day_q = 1;
			if (mon_q >= 12) begin
				mon_q = 1;
				yr_q  = (yr_q >= 9999) ? '0 : yr_q + 1'b1;
			end else begin
				mon_q = mon_q + 1'b1;
			end
		end else begin
			day_q = day_q + 1'b1;
		end
	endfunction

	// One second forward; returns the alarm match after the step
	function automatic logic second_tick();
		if (sec_q >= 59) begin
			sec_q = '0;
			if (min_q >= 59) begin
				min_q = '0;
				if (hr_q >= 23) begin
					hr_q = '0;
					roll_date();
				end else begin
					hr_q = hr_q + 1'b1;
				end
			end else begin
				min_q = min_q + 1'b1;
			end
		end else begin
			sec_q = sec_q + 1'b1;
		end
		// weekday 7 has no mask bit
		return al_en && (wday_q < 7) && al_days[wday_q] && (hr_q == al_hour) &&
			(min_q == al_min) && (sec_q == 0);
	endfunction

	function automatic string word_text(rtc_word_t w);
		return $sformatf("%02d:%02d:%02d wd%0d %0d/%0d/%0d fire=%0b",
			w.hour, w.minute, w.second, w.weekday, w.day, w.month, w.year, w.fire);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rtc_word_t seen;
		rtc_word_t want;
		logic      fire;
		bit        bad;
		if (!arst_n) begin
			hr_q          = '0;
			min_q         = '0;
			sec_q         = '0;
			wday_q        = 6;
			day_q         = 1;
			mon_q         = 1;
			yr_q          = 2000;
			al_hour       = '0;
			al_min        = '0;
			al_en         = 1'b0;
			al_days       = '0;
			readings_due  = {};
			fail_count    = 0;
			shown         = 0;
			leftover_done = 1'b0;
			pending       = 0;
		end else begin
			// Result side first: a word leaving now was predicted at an earlier edge
			if (out_valid && out_ready) begin
				seen = {cur_hour, cur_minute, cur_second, cur_weekday, cur_day, cur_month,
					cur_year, alarm_fire};
				if (readings_due.size() == 0) begin
					fail_count++;
					if (shown < SHOW_LIMIT) begin
						shown++;
						$display("%0t: unexpected word %s", $time, word_text(seen));
					end
				end else begin
					want = readings_due.pop_front();
					bad  = (seen.hour !== want.hour) || (seen.minute !== want.minute) ||
						(seen.second !== want.second) || (seen.weekday !== want.weekday) ||
						(seen.day !== want.day) || (seen.month !== want.month) ||
						(seen.year !== want.year) || (seen.fire !== want.fire);
					if (bad) begin
						fail_count++;
						if (shown < SHOW_LIMIT) begin
							shown++;
							$display("%0t: mismatch, expected %s, got %s", $time,
								word_text(want), word_text(seen));
						end
					end
				end
			end

			// Alarm register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_ALARM_HOUR: al_hour = cfg_data[HOUR_W-1:0];
					CFG_ALARM_MIN:  al_min  = cfg_data[MIN_W-1:0];
					CFG_ALARM_EN:   al_en   = cfg_data[0];
					CFG_ALARM_DAYS: al_days = cfg_data[6:0];
					default: ;
				endcase
			end

			// Accepted word: load or tick, then queue the reading it produces
			if (in_valid && in_ready) begin
				fire = 1'b0;
				if (opcode_t'(opcode) == OP_LOAD) begin
					hr_q   = load_hour;
					min_q  = load_minute;
					sec_q  = load_second;
					wday_q = load_weekday;
					day_q  = load_day;
					mon_q  = load_month;
					yr_q   = load_year;
				end else begin
					fire = second_tick();
				end
				readings_due.push_back({hr_q, min_q, sec_q, wday_q, day_q, mon_q, yr_q, fire});
			end

			if (end_of_test && !leftover_done) begin
				leftover_done = 1'b1;
				if (readings_due.size() != 0) begin
					$display("%0d expected words never came out", readings_due.size());
					fail_count += readings_due.size();
				end
			end
			pending = readings_due.size();
		end
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import rtc_pkg::*;

	localparam int RAND_PHASES = 6;
	localparam int PHASE_WORDS = 190;
	localparam int LONG_HOLD   = 100;
	localparam int DRAIN_WAIT  = 4;
	localparam int DRAIN_LIMIT = 1000;

	typedef struct packed {
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
		logic [WDAY_W-1:0]  weekday;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} load_t;

	localparam int LOAD_BITS = $bits(load_t);

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 opcode;
	logic [HOUR_W-1:0]    load_hour;
	logic [MIN_W-1:0]     load_minute;
	logic [SEC_W-1:0]     load_second;
	logic [WDAY_W-1:0]    load_weekday;
	logic [DAY_W-1:0]     load_day;
	logic [MONTH_W-1:0]   load_month;
	logic [YEAR_W-1:0]    load_year;
	logic                 out_valid;
	logic                 out_ready;
	logic [HOUR_W-1:0]    cur_hour;
	logic [MIN_W-1:0]     cur_minute;
	logic [SEC_W-1:0]     cur_second;
	logic [WDAY_W-1:0]    cur_weekday;
	logic [DAY_W-1:0]     cur_day;
	logic [MONTH_W-1:0]   cur_month;
	logic [YEAR_W-1:0]    cur_year;
	logic                 alarm_fire;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	logic                 end_of_test;
	int                   fail_count;
	int                   pending;
	int                   in_taken;
	int                   cfg_taken;
	int                   hold_asked;
	int                   hold_served;
	bit                   no_idle;
	logic [HOUR_W-1:0]    alarm_h_set;
	logic [MIN_W-1:0]     alarm_m_set;

	rtc_calendar_alarm u_dut (.*);

	rtc_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Handshake counters, read at the falling edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken  <= 0;
			cfg_taken <= 0;
		end else begin
			if (in_valid && in_ready)
				in_taken <= in_taken + 1;
			if (cfg_valid && cfg_ready)
				cfg_taken <= cfg_taken + 1;
		end
	end

	// Mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic load_t random_bits();
		return load_t'(LOAD_BITS'({$urandom, $urandom}));
	endfunction

	function automatic load_t clock_set(int h, int mi, int s, int wd, int d, int mo, int y);
		load_t v;
		v.hour    = HOUR_W'(h);
		v.minute  = MIN_W'(mi);
		v.second  = SEC_W'(s);
		v.weekday = WDAY_W'(wd);
		v.day     = DAY_W'(d);
		v.month   = MONTH_W'(mo);
		v.year    = YEAR_W'(y);
		return v;
	endfunction

	// Load contents that lead somewhere: just before the alarm, just before a
	// month end at midnight, plain valid dates, or raw bit noise
	function automatic load_t random_load();
		load_t v;
		int    secs;
		int    yr;
		int    wd;
		case ($urandom_range(0, 7))
			0: yr = 0;
			1: yr = 1900;
			2: yr = 2000;
			3: yr = 2100;
			4: yr = 2400;
			5: yr = 9999;
			default: yr = $urandom_range(0, 9999);
		endcase
		wd = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				secs = int'(alarm_h_set) * 3600 + int'(alarm_m_set) * 60 -
					int'($urandom_range(1, 6));
				if (secs < 0)
					secs += 86400;
				v = clock_set(secs / 3600, (secs / 60) % 60, secs % 60, wd,
					$urandom_range(1, 28), $urandom_range(1, 12), yr);
			end
			4, 5, 6: begin
				v = clock_set(23, 59, $urandom_range(50, 59), wd, $urandom_range(27, 31),
					$urandom_range(1, 12), yr);
			end
			7, 8: begin
				v = clock_set($urandom_range(0, 23), $urandom_range(0, 59),
					$urandom_range(0, 59), wd, $urandom_range(1, 28),
					$urandom_range(1, 12), yr);
			end
			default: begin
				v = random_bits();
			end
		endcase
		return v;
	endfunction

	// Offer one word and hold it until the block takes it
	task automatic send_word(input opcode_t op, input load_t v);
		int gap;
		int target;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode       <= op;
		load_hour    <= v.hour;
		load_minute  <= v.minute;
		load_second  <= v.second;
		load_weekday <= v.weekday;
		load_day     <= v.day;
		load_month   <= v.month;
		load_year    <= v.year;
		in_valid     <= 1'b1;
		target = in_taken + 1;
		do @(negedge clk); while (in_taken != target);
	endtask

	task automatic load_then_tick(input load_t v);
		send_word(OP_LOAD, v);
		send_word(OP_TICK, random_bits());
	endtask

	// Register write, valid left high for a following write
	task automatic push_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] val);
		int target;
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		target = cfg_taken + 1;
		do @(negedge clk); while (cfg_taken != target);
	endtask

	task automatic set_alarm(input int h, input int mi, input logic en, input logic [6:0] days);
		alarm_h_set = HOUR_W'(h);
		alarm_m_set = MIN_W'(mi);
		push_reg(CFG_ALARM_HOUR, CFG_DAT_W'(h));
		push_reg(CFG_ALARM_MIN, CFG_DAT_W'(mi));
		push_reg(CFG_ALARM_EN, CFG_DAT_W'(en));
		push_reg(CFG_ALARM_DAYS, CFG_DAT_W'(days));
		cfg_valid <= 1'b0;
	endtask

	// Stop offering and let every expected word drain out
	task automatic settle();
		int k;
		in_valid <= 1'b0;
		for (k = 0; k < DRAIN_LIMIT && pending != 0; k++)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		out_ready   = 1'b0;
		hold_served = 0;
		stall_left  = 0;
		forever begin
			@(negedge clk);
			if (hold_asked > hold_served) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_served = hold_served + 1;
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
				out_ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int sent;
		int runs;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = OP_TICK;
		load_hour    = '0;
		load_minute  = '0;
		load_second  = '0;
		load_weekday = '0;
		load_day     = '0;
		load_month   = '0;
		load_year    = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_ALARM_HOUR;
		cfg_data     = '0;
		end_of_test  = 1'b0;
		no_idle      = 1'b0;
		hold_asked   = 0;
		alarm_h_set  = '0;
		alarm_m_set  = '0;
		// reset held first, released on a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Alarm at midnight on every weekday
		set_alarm(0, 0, 1'b1, 7'h7f);
		send_word(OP_TICK, random_bits());
		// year wrap, weekday wrap, alarm at midnight
		load_then_tick(clock_set(23, 59, 59, 6, 31, 12, 9999));
		// century leap year, century non-leap year, plain leap year
		load_then_tick(clock_set(23, 59, 59, 2, 28, 2, 2000));
		load_then_tick(clock_set(23, 59, 59, 3, 28, 2, 1900));
		load_then_tick(clock_set(23, 59, 59, 1, 29, 2, 2024));
		// day past the end of a 30-day month
		load_then_tick(clock_set(23, 59, 59, 4, 31, 6, 2021));
		// counters beyond range, weekday 7, day 0, month 0, widest year
		load_then_tick(clock_set(31, 63, 63, 7, 0, 0, 16383));
		// month 0 goes to January of the same year
		load_then_tick(clock_set(23, 59, 59, 5, 31, 0, 1999));
		// month 15 and a year past 9999
		load_then_tick(clock_set(23, 59, 59, 0, 31, 15, 12000));
		// all zero, a load at midnight leaves the date alone
		load_then_tick(clock_set(0, 0, 0, 0, 0, 0, 0));
		settle();

		// Alarm on Wednesdays at 12:30
		set_alarm(12, 30, 1'b1, 7'h08);
		load_then_tick(clock_set(12, 29, 59, 7, 1, 1, 2000));
		load_then_tick(clock_set(12, 29, 59, 3, 1, 1, 2000));
		send_word(OP_LOAD, clock_set(12, 30, 0, 3, 1, 1, 2000));
		settle();
		set_alarm(12, 30, 1'b0, 7'h08);
		load_then_tick(clock_set(12, 29, 59, 3, 1, 1, 2000));
		settle();

		// Random phases, each under its own alarm setting
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: set_alarm(0, 0, 1'b1, 7'h7f);
				1: set_alarm(23, 59, 1'b1, 7'h7f);
				2: set_alarm($urandom_range(0, 23), $urandom_range(0, 59), 1'b1,
					7'($urandom_range(1, 127)));
				3: set_alarm($urandom_range(0, 23), $urandom_range(0, 59), 1'b0, 7'h7f);
				4: set_alarm($urandom_range(0, 23), $urandom_range(0, 59), 1'b1, 7'h00);
				default: set_alarm($urandom_range(0, 23), $urandom_range(0, 59), 1'b1,
					7'($urandom_range(0, 127)));
			endcase
			no_idle = (ph == 3);
			sent = 0;
			while (sent < PHASE_WORDS) begin
				send_word(OP_LOAD, random_load());
				sent++;
				runs = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90) :
					$urandom_range(1, 12);
				repeat (runs) begin
					send_word(OP_TICK, random_bits());
					sent++;
					// long output stall while words keep coming
					if (ph == 2 && hold_asked == 0 && sent > 40)
						hold_asked = 1;
				end
			end
			settle();
		end

		end_of_test <= 1'b1;
		repeat (2) @(negedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
